### rtl/i2a_pkg.sv
// shared types, codes and helpers of the integer to ascii formatter
package i2a_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned DIG_CNT_W  = 5;
  localparam int unsigned PRE_CHARS  = 5;
  localparam int unsigned PRE_W      = PRE_CHARS * CHAR_W;
  localparam int unsigned PRE_CNT_W  = 3;
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned BCD_W      = DEC_DIGITS * NIB_W;
  localparam int unsigned STEP_CNT_W = 5;

  localparam logic [2:0] KIND_UDEC = 3'd0;
  localparam logic [2:0] KIND_SDEC = 3'd1;
  localparam logic [2:0] KIND_HEXU = 3'd2;
  localparam logic [2:0] KIND_HEXL = 3'd3;
  localparam logic [2:0] KIND_PTR  = 3'd4;

  localparam logic [1:0] SIGN_BLANK = 2'd1;
  localparam logic [1:0] SIGN_PLUS  = 2'd2;

  localparam logic [DIG_CNT_W-1:0] DEC_NDIG   = 5'd10;
  localparam logic [DIG_CNT_W-1:0] HEX32_NDIG = 5'd8;
  localparam logic [DIG_CNT_W-1:0] HEX64_NDIG = 5'd16;
  localparam logic [STEP_CNT_W-1:0] DEC_LAST_STEP = 5'd31;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [PRE_W-1:0]  NIL_TEXT = 40'h28_6e_69_6c_29;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PREFIX,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic skip;
    logic pre_adv;
    logic dig_adv;
    logic sel_pre;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic lead_zero;
    logic has_pre;
    logic pre_last;
    logic dig_last;
    logic no_dig;
  } stat_t;

  function automatic logic [CHAR_W-1:0] nib_char(input logic [NIB_W-1:0] d,
                                                 input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? 8'h37 : 8'h57;
    if (d < 4'd10) begin
      nib_char = CH_ZERO + {4'd0, d};
    end else begin
      nib_char = base + {4'd0, d};
    end
  endfunction

endpackage

### rtl/i2a_if.sv
// channel interfaces for number requests and character results
interface i2a_in_if;
  import i2a_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [VALUE_W-1:0] value;
  logic [1:0]         sign_mode;
  logic               alt_form;

  modport source (output valid, kind, value, sign_mode, alt_form, input ready);
  modport sink   (input valid, kind, value, sign_mode, alt_form, output ready);
endinterface

interface i2a_out_if;
  import i2a_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

### rtl/i2a_ctrl.sv
// sequencing state machine of the formatter
module i2a_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [2:0]     in_kind,
  output logic           in_ready,
  output logic           out_valid,
  output logic           out_last,
  input  logic           out_ready,
  input  i2a_pkg::stat_t stat,
  output i2a_pkg::cmd_t  cmd
);
  import i2a_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_kind <= KIND_PTR) begin
          cmd.load = 1'b1;
          if (in_kind == KIND_UDEC || in_kind == KIND_SDEC) begin
            state_nxt = ST_CONV;
          end else begin
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_CONV: begin
        cmd.dabble = 1'b1;
        if (stat.conv_done) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.lead_zero) begin
          cmd.skip = 1'b1;
        end else if (stat.has_pre) begin
          state_nxt = ST_PREFIX;
        end else begin
          state_nxt = ST_DIGITS;
        end
      end
      ST_PREFIX: begin
        out_valid   = 1'b1;
        cmd.sel_pre = 1'b1;
        out_last    = stat.pre_last && stat.no_dig;
        if (out_ready) begin
          cmd.pre_adv = 1'b1;
          if (stat.pre_last) begin
            state_nxt = stat.no_dig ? ST_IDLE : ST_DIGITS;
          end
        end
      end
      ST_DIGITS: begin
        out_valid = 1'b1;
        out_last  = stat.dig_last;
        if (out_ready) begin
          cmd.dig_adv = 1'b1;
          if (stat.dig_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/i2a_dp.sv
// digit extraction, prefix and character datapath of the formatter
module i2a_dp (
  input  logic                       clk,
  input  logic [2:0]                 in_kind,
  input  logic [i2a_pkg::VALUE_W-1:0] in_value,
  input  logic [1:0]                 in_sign_mode,
  input  logic                       in_alt_form,
  input  i2a_pkg::cmd_t              cmd,
  output i2a_pkg::stat_t             stat,
  output logic [i2a_pkg::CHAR_W-1:0] char_code
);
  import i2a_pkg::*;

  logic [VALUE_W-1:0]    dig_r;
  logic [DIG_CNT_W-1:0]  ndig_r;
  logic [WORD_W-1:0]     bin_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [PRE_W-1:0]      pre_r;
  logic [PRE_CNT_W-1:0]  npre_r;
  logic                  upper_r;

  logic [WORD_W-1:0]     low;
  logic [WORD_W-1:0]     mag;
  logic                  neg;
  logic [VALUE_W-1:0]    ld_dig;
  logic [DIG_CNT_W-1:0]  ld_ndig;
  logic [WORD_W-1:0]     ld_bin;
  logic [PRE_W-1:0]      ld_pre;
  logic [PRE_CNT_W-1:0]  ld_npre;
  logic [BCD_W-1:0]      bcd_adj;

  assign low = in_value[WORD_W-1:0];
  assign neg = low[WORD_W-1];
  assign mag = neg ? (~low + 32'd1) : low;

  // load values per conversion kind
  always_comb begin
    ld_dig  = '0;
    ld_ndig = DEC_NDIG;
    ld_bin  = low;
    ld_pre  = '0;
    ld_npre = 3'd0;
    case (in_kind)
      KIND_UDEC: begin
        ld_bin = low;
      end
      KIND_SDEC: begin
        ld_bin = mag;
        if (neg) begin
          ld_pre  = {CH_MINUS, 32'd0};
          ld_npre = 3'd1;
        end else if (in_sign_mode == SIGN_BLANK) begin
          ld_pre  = {CH_SPACE, 32'd0};
          ld_npre = 3'd1;
        end else if (in_sign_mode == SIGN_PLUS) begin
          ld_pre  = {CH_PLUS, 32'd0};
          ld_npre = 3'd1;
        end
      end
      KIND_HEXU, KIND_HEXL: begin
        ld_dig  = {low, 32'd0};
        ld_ndig = HEX32_NDIG;
        if (in_alt_form && low != '0) begin
          ld_pre  = {CH_ZERO, (in_kind == KIND_HEXU) ? CH_X_UP : CH_X_LO, 24'd0};
          ld_npre = 3'd2;
        end
      end
      KIND_PTR: begin
        if (in_value == '0) begin
          ld_pre  = NIL_TEXT;
          ld_npre = 3'd5;
          ld_ndig = 5'd0;
        end else begin
          ld_dig  = in_value;
          ld_ndig = HEX64_NDIG;
          ld_pre  = {CH_ZERO, CH_X_LO, 24'd0};
          ld_npre = 3'd2;
        end
      end
      default: begin
        ld_ndig = 5'd0;
      end
    endcase
  end

  // add-three correction on each bcd digit before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      logic [NIB_W-1:0] d;
      d = dig_r[VALUE_W-BCD_W + i*NIB_W +: NIB_W];
      bcd_adj[i*NIB_W +: NIB_W] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dig_r   <= ld_dig;
      ndig_r  <= ld_ndig;
      bin_r   <= ld_bin;
      cnt_r   <= DEC_LAST_STEP;
      pre_r   <= ld_pre;
      npre_r  <= ld_npre;
      upper_r <= (in_kind == KIND_HEXU);
    end else if (cmd.dabble) begin
      dig_r[VALUE_W-1 -: BCD_W] <= {bcd_adj[BCD_W-2:0], bin_r[WORD_W-1]};
      bin_r <= {bin_r[WORD_W-2:0], 1'b0};
      cnt_r <= cnt_r - 5'd1;
    end else begin
      if (cmd.skip || cmd.dig_adv) begin
        dig_r  <= {dig_r[VALUE_W-NIB_W-1:0], {NIB_W{1'b0}}};
        ndig_r <= ndig_r - 5'd1;
      end
      if (cmd.pre_adv) begin
        pre_r  <= {pre_r[PRE_W-CHAR_W-1:0], {CHAR_W{1'b0}}};
        npre_r <= npre_r - 3'd1;
      end
    end
  end

  assign stat.conv_done = (cnt_r == '0);
  assign stat.lead_zero = (dig_r[VALUE_W-1 -: NIB_W] == '0) && (ndig_r > 5'd1);
  assign stat.has_pre   = (npre_r != '0);
  assign stat.pre_last  = (npre_r == 3'd1);
  assign stat.dig_last  = (ndig_r == 5'd1);
  assign stat.no_dig    = (ndig_r == '0);

  assign char_code = cmd.sel_pre ? pre_r[PRE_W-1 -: CHAR_W]
                                 : nib_char(dig_r[VALUE_W-1 -: NIB_W], upper_r);

endmodule

### rtl/integer_to_ascii_formatter_core.sv
// top level of the integer to ascii formatter
// one number at a time: decimal kinds load, then run the bit-serial shift-add-3 conversion;
// hex kinds only load; then leading zero digits are dropped, one per step,
// after that one character per cycle while out ready is high: up to 18 for a pointer
// synchronous active-low reset returns the sequencer to idle; datapath holds no reset
module integer_to_ascii_formatter_core (
  input logic       clk,
  input logic       rst_n,
  i2a_in_if.sink    in_ch,
  i2a_out_if.source out_ch
);
  import i2a_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  i2a_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_last  (out_ch.last),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  i2a_dp u_dp (
    .clk          (clk),
    .in_kind      (in_ch.kind),
    .in_value     (in_ch.value),
    .in_sign_mode (in_ch.sign_mode),
    .in_alt_form  (in_ch.alt_form),
    .cmd          (cmd),
    .stat         (stat),
    .char_code    (out_ch.char_code)
  );

endmodule

### rtl/i2a_checker.sv
// port-level checks of the formatter and their binding to the top level
module i2a_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [2:0]                  in_kind,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [i2a_pkg::CHAR_W-1:0]  out_char_code,
  input logic                        out_last
);
  import i2a_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last))
    else $error("result changed while stalled");

  // one number at a time: no new request while characters are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result is offered");

  // a valid request blocks the input until its text is done
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind <= KIND_PTR) |=> !in_ready && !out_valid)
    else $error("request not taken into conversion");

  // final character returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("not idle after last character");

  // a character that is not last is followed by another
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("text ended without last flag");

endmodule

bind integer_to_ascii_formatter_core i2a_checker u_i2a_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_kind       (in_ch.kind),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_char_code (out_ch.char_code),
  .out_last      (out_ch.last)
);

### tb/sv/tb.sv
// self-checking testbench for the integer to ascii formatter core
`timescale 1ns / 1ps

module tb;
  import i2a_pkg::*;

  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
  localparam logic [1:0] SIGN_NONE        = 2'd0;
  localparam logic [1:0] SIGN_SPARE       = 2'd3;
  localparam int         RANDOM_NUMBERS   = 446;
  localparam int         DRAIN_CYCLES     = 100;
  localparam int         CYCLE_LIMIT      = 800000;
  localparam int         REPORT_MAX       = 10;

  typedef struct packed {
    logic [2:0]         kind;
    logic [VALUE_W-1:0] value;
    logic [1:0]         sign_mode;
    logic               alt_form;
  } num_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } text_char_t;

  logic clk;
  logic rst_n;

  i2a_in_if  in_ch ();
  i2a_out_if out_ch ();

  integer_to_ascii_formatter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  num_req_t   pending_numbers[$];
  text_char_t expected_chars[$];
  num_req_t   drv_req;
  int         burst_left;
  int         gap_left;
  logic [15:0] stall_pat;
  int         pat_left;
  int         cyc;
  int         err_cnt;
  int         chars_checked;
  int         kind_cnt[8];

  always #1 clk = ~clk;

  function automatic void note_mismatch(input string msg);
    if (err_cnt < REPORT_MAX) begin
      $display("mismatch: %s", msg);
    end
    err_cnt++;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    if (d < 4'd10) begin
      return "0" + d;
    end else if (upper) begin
      return "A" + d - 4'd10;
    end else begin
      return "a" + d - 4'd10;
    end
  endfunction

  // work out the characters of one number and queue them
  function automatic void format_number(input num_req_t r);
    logic [CHAR_W-1:0]  txt [0:23];
    logic [CHAR_W-1:0]  dig [0:19];
    logic [39:0]        nil_word;
    logic [WORD_W-1:0]  low;
    logic [VALUE_W-1:0] mag;
    logic               hex;
    logic               upper;
    int                 n;
    int                 nd;
    text_char_t         tc;
    low      = r.value[WORD_W-1:0];
    nil_word = "(nil)";
    mag      = '0;
    hex      = 1'b0;
    upper    = 1'b0;
    n        = 0;
    case (r.kind)
      KIND_UDEC: begin
        mag = {32'd0, low};
      end
      KIND_SDEC: begin
        if (low[31]) begin
          txt[n] = "-";
          n++;
          mag = {32'd0, (~low) + 32'd1};
        end else begin
          if (r.sign_mode == SIGN_BLANK) begin
            txt[n] = " ";
            n++;
          end else if (r.sign_mode == SIGN_PLUS) begin
            txt[n] = "+";
            n++;
          end
          mag = {32'd0, low};
        end
      end
      KIND_HEXU, KIND_HEXL: begin
        hex   = 1'b1;
        upper = (r.kind == KIND_HEXU);
        if (r.alt_form && low != '0) begin
          txt[n]     = "0";
          txt[n + 1] = upper ? "X" : "x";
          n += 2;
        end
        mag = {32'd0, low};
      end
      KIND_PTR: begin
        if (r.value == '0) begin
          for (int k = 0; k < 5; k++) begin
            tc.char_code = nil_word[39 - 8 * k -: 8];
            tc.last      = (k == 4);
            expected_chars.push_back(tc);
          end
          return;
        end
        hex        = 1'b1;
        txt[0]     = "0";
        txt[1]     = "x";
        n          = 2;
        mag        = r.value;
      end
      default: begin
        return;
      end
    endcase
    nd = 0;
    if (mag == '0) begin
      dig[0] = "0";
      nd     = 1;
    end else begin
      while (mag != '0) begin
        if (hex) begin
          dig[nd] = digit_char(mag[3:0], upper);
          mag     = mag >> 4;
        end else begin
          dig[nd] = digit_char(4'(mag % 64'd10), 1'b0);
          mag     = mag / 64'd10;
        end
        nd++;
      end
    end
    for (int k = nd - 1; k >= 0; k--) begin
      txt[n] = dig[k];
      n++;
    end
    for (int k = 0; k < n; k++) begin
      tc.char_code = txt[k];
      tc.last      = (k == n - 1);
      expected_chars.push_back(tc);
    end
  endfunction

  function automatic void queue_number(input logic [2:0] kind, input logic [VALUE_W-1:0] value,
                                       input logic [1:0] sign_mode, input logic alt_form);
    num_req_t r;
    r.kind      = kind;
    r.value     = value;
    r.sign_mode = sign_mode;
    r.alt_form  = alt_form;
    pending_numbers.push_back(r);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    logic [WORD_W-1:0]  hi;
    hi = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
    case ($urandom_range(0, 4))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: v = {hi, 32'($urandom_range(0, 20))};
      3: v = {hi, $urandom} >> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 4))
          0: v = {hi, 32'h0000_0000};
          1: v = {hi, 32'hffff_ffff};
          2: v = {hi, 32'h8000_0000};
          3: v = {hi, 32'h7fff_ffff};
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  // sender: bursts of transfers with random gaps
  always @(posedge clk) begin : drive_numbers
    num_req_t nxt;
    logic     took;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        format_number(drv_req);
        kind_cnt[drv_req.kind]++;
      end
      if (!in_ch.valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_numbers.size() != 0) begin
          nxt                = pending_numbers.pop_front();
          drv_req            = nxt;
          in_ch.kind        <= nxt.kind;
          in_ch.value       <= nxt.value;
          in_ch.sign_mode   <= nxt.sign_mode;
          in_ch.alt_form    <= nxt.alt_form;
          in_ch.valid       <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0) begin
              gap_left = 0;
            end else if ($urandom_range(0, 4) == 0) begin
              gap_left = $urandom_range(20, 60);
            end else begin
              gap_left = $urandom_range(1, 8);
            end
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, replaced now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (pat_left <= 0) begin
        pat_left = $urandom_range(40, 160);
        case ($urandom_range(0, 4))
          0: stall_pat = 16'hffff;
          1: stall_pat = 16'h0001;
          2: stall_pat = 16'hff00;
          default: stall_pat = 16'($urandom) | 16'h0001;
        endcase
      end else begin
        pat_left--;
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
      out_ch.ready <= stall_pat[0];
    end
  end

  always @(posedge clk) begin : check_chars
    text_char_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected char 8'h%02h last %0b", out_ch.char_code,
                                out_ch.last));
      end else begin
        e = expected_chars.pop_front();
        chars_checked++;
        if (out_ch.char_code !== e.char_code || out_ch.last !== e.last) begin
          note_mismatch($sformatf("char exp 8'h%02h last %0b, got 8'h%02h last %0b",
                                  e.char_code, e.last, out_ch.char_code, out_ch.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int counted;
    logic [2:0] k;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_UDEC;
    in_ch.value      = '0;
    in_ch.sign_mode  = SIGN_NONE;
    in_ch.alt_form   = 1'b0;
    out_ch.ready     = 1'b0;
    burst_left       = 1;
    gap_left         = 0;
    stall_pat        = 16'hffff;
    pat_left         = 0;
    cyc              = 0;
    err_cnt          = 0;
    chars_checked    = 0;
    counted          = 0;
    foreach (kind_cnt[i]) kind_cnt[i] = 0;

    // directed corners
    queue_number(KIND_UDEC, 64'h0, SIGN_NONE, 1'b0);
    queue_number(KIND_UDEC, 64'hffff_ffff_0000_0000, SIGN_PLUS, 1'b1);
    queue_number(KIND_UDEC, 64'ha5a5_a5a5_ffff_ffff, SIGN_NONE, 1'b0);
    queue_number(KIND_UDEC, 64'd42, SIGN_PLUS, 1'b1);
    queue_number(KIND_SDEC, 64'h8000_0000, SIGN_PLUS, 1'b0);
    queue_number(KIND_SDEC, 64'h7fff_ffff, SIGN_NONE, 1'b0);
    queue_number(KIND_SDEC, 64'h0, SIGN_BLANK, 1'b0);
    queue_number(KIND_SDEC, 64'h0, SIGN_PLUS, 1'b1);
    queue_number(KIND_SDEC, 64'd5, SIGN_SPARE, 1'b0);
    queue_number(KIND_SDEC, 64'hffff_ffff, SIGN_PLUS, 1'b0);
    queue_number(KIND_SDEC, 64'hffff_ffff_0000_0007, SIGN_BLANK, 1'b0);
    queue_number(KIND_HEXU, 64'h0, SIGN_NONE, 1'b1);
    queue_number(KIND_HEXU, 64'hdead_beef, SIGN_NONE, 1'b1);
    queue_number(KIND_HEXU, 64'hffff_ffff, SIGN_PLUS, 1'b0);
    queue_number(KIND_HEXL, 64'h0, SIGN_BLANK, 1'b0);
    queue_number(KIND_HEXL, 64'h1234_5678_0000_000a, SIGN_NONE, 1'b1);
    queue_number(KIND_HEXL, 64'hffff_ffff, SIGN_NONE, 1'b1);
    queue_number(KIND_PTR, 64'h0, SIGN_NONE, 1'b1);
    queue_number(KIND_PTR, 64'hffff_ffff_ffff_ffff, SIGN_NONE, 1'b0);
    queue_number(KIND_PTR, 64'h0000_0001_0000_0000, SIGN_NONE, 1'b0);
    queue_number(KIND_PTR, 64'h1, SIGN_PLUS, 1'b0);
    queue_number(KIND_SPARE_FIRST, 64'hffff_ffff_ffff_ffff, SIGN_PLUS, 1'b1);
    queue_number(KIND_SPARE_MID, 64'h0, SIGN_NONE, 1'b0);
    queue_number(KIND_SPARE_LAST, 64'd123, SIGN_BLANK, 1'b1);

    while (counted < RANDOM_NUMBERS) begin
      k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST))
                                       : 3'($urandom_range(KIND_UDEC, KIND_PTR));
      queue_number(k, random_value(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      counted++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_numbers.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    while (expected_chars.size() != 0) begin
      void'(expected_chars.pop_front());
      note_mismatch("expected char never arrived");
    end

    $display("numbers: %0d udec, %0d sdec, %0d hex upper, %0d hex lower, %0d ptr, %0d unused",
             kind_cnt[KIND_UDEC], kind_cnt[KIND_SDEC], kind_cnt[KIND_HEXU],
             kind_cnt[KIND_HEXL], kind_cnt[KIND_PTR],
             kind_cnt[KIND_SPARE_FIRST] + kind_cnt[KIND_SPARE_MID] +
             kind_cnt[KIND_SPARE_LAST]);
    $display("%0d characters checked in %0d cycles, %0d mismatches", chars_checked, cyc,
             err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/i2a_pkg.sv
rtl/i2a_if.sv
rtl/i2a_ctrl.sv
rtl/i2a_dp.sv
rtl/integer_to_ascii_formatter_core.sv
rtl/i2a_checker.sv
tb/sv/tb.sv
